// File: hdl/tsio_pkg.sv
// Shared types and constants for the timer / serial I/O page.
// No dependencies; used by timer_serial_io_page and its checker.
package tsio_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_RX    = 2'd3
    } t_op;

    localparam int RX_FIFO_DEPTH_DEF = 16;

    // register offsets within the page
    localparam logic [7:0] OFF_RELOAD_LO = 8'h00;
    localparam logic [7:0] OFF_RELOAD_HI = 8'h01;
    localparam logic [7:0] OFF_TIMER_CTL = 8'h02;
    localparam logic [7:0] OFF_SER_DATA  = 8'h10;
    localparam logic [7:0] OFF_SER_STAT  = 8'h11;
    localparam logic [7:0] OFF_SER_CTL   = 8'h12;

    // timer control bits
    localparam int CTL_EN_BIT     = 0;
    localparam int CTL_IRQ_EN_BIT = 1;
    localparam int CTL_RELOAD_BIT = 2;
    localparam int CTL_CLR_BIT    = 7;

    // serial control / status bits
    localparam int SER_RX_IRQ_EN_BIT = 0;
    localparam logic [7:0] STAT_TX_READY = 8'h02;
    localparam logic [7:0] STAT_RX_AVAIL = 8'h01;

    localparam int PERIOD_W = 17;
    localparam logic [PERIOD_W-1:0] TIMER_FULL_PERIOD = 17'h10000;

endpackage

// File: hdl/timer_serial_io_page.sv
// Timer / serial I/O page top level.
// Depends on tsio_pkg and tsio_ram (receive FIFO storage).
//
// Each request (bus read, bus write, timer tick or received byte) is accepted
// and its result appears in the output register on the next edge;
// a new request is taken every cycle as long as the result register is empty
// or being drained, so the sustained rate is one request per clock. The
// critical path is the 64-bit cycle compare and the 64-bit fire-time add that
// feed the timer state. The receive FIFO sits in a RAM with registered read;
// its read port is always addressed by the next read pointer, with a bypass
// for a byte written to that same slot, so a pop returns data with no stall.
// No clearing pass is needed after reset.
module timer_serial_io_page
    import tsio_pkg::*;
#(
    parameter int RX_FIFO_DEPTH = RX_FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_offset,
    input  logic [7:0]  i_write_data,
    input  logic [63:0] i_cycle_now,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_irq,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_rx_accepted
);

    localparam int PTR_W = $clog2(RX_FIFO_DEPTH);
    localparam int CNT_W = $clog2(RX_FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RX_FIFO_DEPTH);

    // architectural state
    logic [15:0]      r_reload,  n_reload;
    logic [6:0]       r_ctl,     n_ctl;
    logic             r_flag,    n_flag;
    logic [63:0]      r_fire,    n_fire;
    logic [7:0]       r_ser_ctl, n_ser_ctl;
    logic [PTR_W-1:0] r_rd_ptr,  n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr,  n_wr_ptr;
    logic [CNT_W-1:0] r_count,   n_count;

    // result register
    logic       r_valid;
    logic [7:0] r_read_data,   n_read_data;
    logic       r_irq,         n_irq;
    logic       r_tx_valid,    n_tx_valid;
    logic [7:0] r_tx_byte,     n_tx_byte;
    logic       r_rx_accepted, n_rx_accepted;

    // FIFO read bypass
    logic       r_fwd_hit;
    logic [7:0] r_fwd_data;
    logic [7:0] ram_q;
    logic [7:0] fifo_head;
    logic       push;

    logic                accept;
    t_op                 op;
    logic [PERIOD_W-1:0] period;
    logic                add_from_now;
    logic [63:0]         fire_sum;
    logic                fire_due;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign op      = t_op'(i_op);

    assign period = (r_reload == 16'd0) ? TIMER_FULL_PERIOD : {1'b0, r_reload};

    // one adder serves both arming (from now) and auto-reload (from fire time)
    assign add_from_now = (op == OP_WRITE);
    assign fire_sum = (add_from_now ? i_cycle_now : r_fire)
                      + {{(64 - PERIOD_W){1'b0}}, period};
    assign fire_due = (i_cycle_now >= r_fire);

    assign fifo_head = r_fwd_hit ? r_fwd_data : ram_q;

    always_comb begin
        n_reload      = r_reload;
        n_ctl         = r_ctl;
        n_flag        = r_flag;
        n_fire        = r_fire;
        n_ser_ctl     = r_ser_ctl;
        n_rd_ptr      = r_rd_ptr;
        n_wr_ptr      = r_wr_ptr;
        n_count       = r_count;
        n_read_data   = 8'd0;
        n_tx_valid    = 1'b0;
        n_tx_byte     = 8'd0;
        n_rx_accepted = 1'b0;
        push          = 1'b0;

        if (accept) begin
            case (op)
                OP_READ: begin
                    case (i_offset)
                        OFF_RELOAD_LO: n_read_data = r_reload[7:0];
                        OFF_RELOAD_HI: n_read_data = r_reload[15:8];
                        OFF_TIMER_CTL: n_read_data = {r_flag, r_ctl};
                        OFF_SER_DATA: begin
                            if (r_count != '0) begin
                                n_read_data = fifo_head;
                                n_rd_ptr    = (r_rd_ptr == PTR_LAST) ? '0
                                                                     : r_rd_ptr + 1'b1;
                                n_count     = r_count - 1'b1;
                            end
                        end
                        OFF_SER_STAT: n_read_data = STAT_TX_READY
                                          | ((r_count != '0) ? STAT_RX_AVAIL : 8'd0);
                        OFF_SER_CTL:  n_read_data = r_ser_ctl;
                        default:      n_read_data = 8'd0;
                    endcase
                end
                OP_WRITE: begin
                    case (i_offset)
                        OFF_RELOAD_LO: n_reload[7:0]  = i_write_data;
                        OFF_RELOAD_HI: n_reload[15:8] = i_write_data;
                        OFF_TIMER_CTL: begin
                            if (i_write_data[CTL_CLR_BIT]) begin
                                n_flag = 1'b0;
                            end
                            n_ctl = i_write_data[6:0];
                            // arm on a rising edge of enable
                            if (!r_ctl[CTL_EN_BIT] && i_write_data[CTL_EN_BIT]) begin
                                n_fire = fire_sum;
                            end
                        end
                        OFF_SER_DATA: begin
                            n_tx_valid = 1'b1;
                            n_tx_byte  = i_write_data;
                        end
                        OFF_SER_CTL: n_ser_ctl = i_write_data;
                        default: ;
                    endcase
                end
                OP_TICK: begin
                    if (r_ctl[CTL_EN_BIT] && fire_due) begin
                        n_flag = 1'b1;
                        if (r_ctl[CTL_RELOAD_BIT]) begin
                            n_fire = fire_sum;
                        end else begin
                            n_ctl[CTL_EN_BIT] = 1'b0;
                        end
                    end
                end
                OP_RX: begin
                    // drop the byte when full
                    if (r_count != CNT_FULL) begin
                        push          = 1'b1;
                        n_wr_ptr      = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
                        n_count       = r_count + 1'b1;
                        n_rx_accepted = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        n_irq = (n_flag && n_ctl[CTL_IRQ_EN_BIT])
                || ((n_count != '0) && n_ser_ctl[SER_RX_IRQ_EN_BIT]);
    end

    tsio_ram #(
        .WIDTH (8),
        .DEPTH (RX_FIFO_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_write_data),
        .i_raddr (n_rd_ptr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload  <= '0;
            r_ctl     <= '0;
            r_flag    <= 1'b0;
            r_fire    <= '0;
            r_ser_ctl <= '0;
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_count   <= '0;
            r_valid   <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_reload  <= n_reload;
            r_ctl     <= n_ctl;
            r_flag    <= n_flag;
            r_fire    <= n_fire;
            r_ser_ctl <= n_ser_ctl;
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_count   <= n_count;
            r_fwd_hit <= push && (r_wr_ptr == n_rd_ptr);
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_write_data;
        if (accept) begin
            r_read_data   <= n_read_data;
            r_irq         <= n_irq;
            r_tx_valid    <= n_tx_valid;
            r_tx_byte     <= n_tx_byte;
            r_rx_accepted <= n_rx_accepted;
        end
    end

    assign o_valid       = r_valid;
    assign o_read_data   = r_read_data;
    assign o_irq         = r_irq;
    assign o_tx_valid    = r_tx_valid;
    assign o_tx_byte     = r_tx_byte;
    assign o_rx_accepted = r_rx_accepted;

endmodule

// File: hdl/tsio_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/tsio_chk.sv
// Port-level checker for timer_serial_io_page, attached by bind.
// Depends on tsio_pkg for op codes and register offsets.
module tsio_chk
    import tsio_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_op,
    input logic [7:0]  i_offset,
    input logic [7:0]  i_write_data,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_read_data,
    input logic        o_tx_valid,
    input logic [7:0]  o_tx_byte,
    input logic        o_rx_accepted
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data) && $stable(o_tx_byte)
                                && $stable(o_tx_valid) && $stable(o_rx_accepted))
        else $error("result changed while stalled");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tx_valid |-> o_tx_byte == 8'd0)
        else $error("tx byte nonzero without tx");

    a_tick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_op == OP_TICK |=>
            o_valid && o_read_data == 8'd0 && !o_tx_valid && !o_rx_accepted)
        else $error("tick request produced data");

    a_tx_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_op == OP_WRITE && i_offset == OFF_SER_DATA |=>
            o_valid && o_tx_valid && o_tx_byte == $past(i_write_data))
        else $error("tx write did not emit its byte");

endmodule

bind timer_serial_io_page tsio_chk u_tsio_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_op          (i_op),
    .i_offset      (i_offset),
    .i_write_data  (i_write_data),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_read_data   (o_read_data),
    .o_tx_valid    (o_tx_valid),
    .o_tx_byte     (o_tx_byte),
    .o_rx_accepted (o_rx_accepted)
);

// File: dv/timer_serial_io_page_tb.sv
// Self-checking bench for timer_serial_io_page: drives requests, predicts each result.
// Depends on tsio_pkg and timer_serial_io_page; the scoreboard class holds the page model.
`timescale 1ns / 100ps

module timer_serial_io_page_tb;
    import tsio_pkg::*;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_accepted;
    } t_page_result;

    class io_page_scoreboard;
        logic [15:0]  reload;
        logic [6:0]   timer_ctl;
        logic         timer_flag;
        logic [63:0]  fire_at;
        logic [7:0]   serial_ctl;
        logic [7:0]   rx_bytes [RX_FIFO_DEPTH_DEF];
        int           rx_head;
        int           rx_tail;
        int           rx_level;
        t_page_result expected_q [$];
        int           fail_count;

        function new();
            reload     = '0;
            timer_ctl  = '0;
            timer_flag = 1'b0;
            fire_at    = '0;
            serial_ctl = '0;
            rx_head    = 0;
            rx_tail    = 0;
            rx_level   = 0;
            fail_count = 0;
        endfunction

        function logic [63:0] period_cycles();
            return (reload == 16'd0) ? 64'(TIMER_FULL_PERIOD) : 64'(reload);
        endfunction

        function logic [7:0] read_register(logic [7:0] offset);
            logic [7:0] b;
            case (offset)
                OFF_RELOAD_LO: return reload[7:0];
                OFF_RELOAD_HI: return reload[15:8];
                OFF_TIMER_CTL: return {timer_flag, timer_ctl};
                OFF_SER_DATA: begin
                    // pop; an empty FIFO reads as zero and stays put
                    if (rx_level == 0)
                        return 8'h00;
                    b = rx_bytes[rx_head];
                    rx_head = (rx_head + 1) % RX_FIFO_DEPTH_DEF;
                    rx_level--;
                    return b;
                end
                OFF_SER_STAT: return STAT_TX_READY | ((rx_level != 0) ? STAT_RX_AVAIL : 8'h00);
                OFF_SER_CTL: return serial_ctl;
                default: return 8'h00;
            endcase
        endfunction

        function void note_request(t_op op, logic [7:0] offset, logic [7:0] data,
                                   logic [63:0] now);
            t_page_result r;
            logic         was_on;
            r = '0;
            case (op)
                OP_READ: r.read_data = read_register(offset);
                OP_WRITE: begin
                    case (offset)
                        OFF_RELOAD_LO: reload[7:0] = data;
                        OFF_RELOAD_HI: reload[15:8] = data;
                        OFF_TIMER_CTL: begin
                            was_on = timer_ctl[CTL_EN_BIT];
                            if (data[CTL_CLR_BIT])
                                timer_flag = 1'b0;
                            timer_ctl = data[6:0];
                            // arm on a rising edge of enable only
                            if (!was_on && data[CTL_EN_BIT])
                                fire_at = now + period_cycles();
                        end
                        OFF_SER_DATA: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = data;
                        end
                        OFF_SER_CTL: serial_ctl = data;
                        default: ;
                    endcase
                end
                OP_TICK: begin
                    if (timer_ctl[CTL_EN_BIT] && now >= fire_at) begin
                        timer_flag = 1'b1;
                        if (timer_ctl[CTL_RELOAD_BIT])
                            fire_at = fire_at + period_cycles();
                        else
                            timer_ctl[CTL_EN_BIT] = 1'b0;
                    end
                end
                OP_RX: begin
                    if (rx_level < RX_FIFO_DEPTH_DEF) begin
                        rx_bytes[rx_tail] = data;
                        rx_tail = (rx_tail + 1) % RX_FIFO_DEPTH_DEF;
                        rx_level++;
                        r.rx_accepted = 1'b1;
                    end
                end
                default: ;
            endcase
            r.irq = (timer_flag && timer_ctl[CTL_IRQ_EN_BIT]) ||
                    (rx_level != 0 && serial_ctl[SER_RX_IRQ_EN_BIT]);
            expected_q.push_back(r);
        endfunction

        function void record_failure(string what);
            fail_count++;
            if (fail_count <= 10)
                $display("%s", what);
        endfunction

        function void check_result(t_page_result got);
            t_page_result want;
            if (expected_q.size() == 0) begin
                record_failure($sformatf("%0t: result with no request pending: rd=%02h irq=%0b",
                                         $realtime, got.read_data, got.irq));
                return;
            end
            want = expected_q.pop_front();
            if (got.read_data !== want.read_data || got.irq !== want.irq ||
                got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                got.rx_accepted !== want.rx_accepted)
                record_failure({
                    $sformatf("%0t: mismatch exp rd=%02h irq=%0b txv=%0b txb=%02h rxa=%0b,",
                              $realtime, want.read_data, want.irq, want.tx_valid,
                              want.tx_byte, want.rx_accepted),
                    $sformatf(" got rd=%02h irq=%0b txv=%0b txb=%02h rxa=%0b",
                              got.read_data, got.irq, got.tx_valid, got.tx_byte,
                              got.rx_accepted)});
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void flush_leftover();
            while (expected_q.size() != 0) begin
                void'(expected_q.pop_front());
                record_failure("request never answered");
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_ready;
    t_op          i_op;
    logic [7:0]   i_offset;
    logic [7:0]   i_write_data;
    logic [63:0]  i_cycle_now;
    logic         o_valid;
    logic         i_ready;
    logic [7:0]   o_read_data;
    logic         o_irq;
    logic         o_tx_valid;
    logic [7:0]   o_tx_byte;
    logic         o_rx_accepted;

    io_page_scoreboard sb = new();
    t_page_result      observed;
    logic [63:0]       clock_count;
    int                items_sent;
    bit                quiet;
    bit                hold_req;
    int                hold_left;

    timer_serial_io_page uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_offset      (i_offset),
        .i_write_data  (i_write_data),
        .i_cycle_now   (i_cycle_now),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_data   (o_read_data),
        .o_irq         (o_irq),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_rx_accepted (o_rx_accepted)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timer_serial_io_page_tb failed");
        $finish;
    end

    // one process sees both handshakes, so a request is always noted before its result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_request(i_op, i_offset, i_write_data, i_cycle_now);
            if (o_valid && i_ready) begin
                observed.read_data   = o_read_data;
                observed.irq         = o_irq;
                observed.tx_valid    = o_tx_valid;
                observed.tx_byte     = o_tx_byte;
                observed.rx_accepted = o_rx_accepted;
                sb.check_result(observed);
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        i_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else begin
                i_ready = quiet || ($urandom_range(99) >= 10);
            end
        end
    end

    task automatic send_request(t_op op, logic [7:0] offset, logic [7:0] data,
                                logic [63:0] now);
        @(negedge i_clk);
        i_valid      = 1'b1;
        i_op         = op;
        i_offset     = offset;
        i_write_data = data;
        i_cycle_now  = now;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    task automatic hold_valid_low(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    task automatic issue(t_op op, logic [7:0] offset, logic [7:0] data);
        if (!quiet && $urandom_range(99) < 10)
            hold_valid_low($urandom_range(1, 3));
        clock_count = clock_count + 64'($urandom_range(1, 8));
        send_request(op, offset, data, clock_count);
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic program_timer();
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] ctl;
        lo  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
        hi  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00;
        ctl = 8'($urandom);
        issue(OP_WRITE, OFF_RELOAD_LO, lo);
        issue(OP_WRITE, OFF_RELOAD_HI, hi);
        // drop enable first most of the time so the next write re-arms
        if ($urandom_range(3) != 0)
            issue(OP_WRITE, OFF_TIMER_CTL, ctl & 8'hFE);
        issue(OP_WRITE, OFF_TIMER_CTL, ctl | 8'h01);
    endtask

    task automatic read_mapped();
        case ($urandom_range(5))
            0: issue(OP_READ, OFF_RELOAD_LO, 8'($urandom));
            1: issue(OP_READ, OFF_RELOAD_HI, 8'($urandom));
            2: issue(OP_READ, OFF_TIMER_CTL, 8'($urandom));
            3: issue(OP_READ, OFF_SER_DATA, 8'($urandom));
            4: issue(OP_READ, OFF_SER_STAT, 8'($urandom));
            default: issue(OP_READ, OFF_SER_CTL, 8'($urandom));
        endcase
    endtask

    initial begin
        int  pick;
        int  n;
        int  guard;
        bit  hold_done;
        bit  pause_done;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_op         = OP_READ;
        i_offset     = '0;
        i_write_data = '0;
        i_cycle_now  = '0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        items_sent   = 0;
        clock_count  = 64'd1000;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values, empty pop, unmapped read
        send_request(OP_READ, OFF_RELOAD_LO, 8'h00, 64'd0);
        send_request(OP_READ, OFF_TIMER_CTL, 8'hFF, 64'd1);
        send_request(OP_READ, OFF_SER_DATA, 8'h00, 64'd2);
        send_request(OP_READ, OFF_SER_STAT, 8'h00, 64'd3);
        send_request(OP_READ, OFF_SER_CTL, 8'h00, 64'd4);
        send_request(OP_READ, 8'hFF, 8'h00, 64'd5);
        send_request(OP_WRITE, OFF_RELOAD_LO, 8'hFF, 64'd6);
        send_request(OP_WRITE, OFF_RELOAD_HI, 8'hFF, 64'd7);
        send_request(OP_READ, OFF_RELOAD_HI, 8'h00, 64'd8);
        // reload of zero means a full period (TIMER_FULL_PERIOD)
        send_request(OP_WRITE, OFF_RELOAD_LO, 8'h00, 64'd9);
        send_request(OP_WRITE, OFF_RELOAD_HI, 8'h00, 64'd10);
        send_request(OP_WRITE, OFF_SER_CTL, 8'hFF, 64'd11);
        send_request(OP_WRITE, OFF_SER_STAT, 8'hFF, 64'd12);
        send_request(OP_WRITE, 8'h5A, 8'hAA, 64'd13);
        send_request(OP_WRITE, OFF_SER_DATA, 8'hA5, 64'd14);
        // arm near the top of the count so the fire time wraps
        send_request(OP_WRITE, OFF_TIMER_CTL, 8'h87, 64'hFFFF_FFFF_FFFF_FFF0);
        send_request(OP_TICK, 8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_WRITE, OFF_TIMER_CTL, 8'h80, 64'hFFFF_FFFF_FFFF_FFFF);
        // one-shot: early tick does nothing, on-time tick fires and disables
        send_request(OP_WRITE, OFF_RELOAD_LO, 8'h03, 64'd99);
        send_request(OP_WRITE, OFF_TIMER_CTL, 8'h03, 64'd100);
        send_request(OP_TICK, 8'h00, 8'h00, 64'd101);
        send_request(OP_TICK, 8'h00, 8'h00, 64'd103);
        send_request(OP_RX, 8'h00, 8'hFF, 64'd104);
        send_request(OP_READ, OFF_SER_DATA, 8'h00, 64'd105);
        send_request(OP_READ, OFF_SER_DATA, 8'h00, 64'd106);

        while (items_sent < 1050) begin
            if (items_sent >= 300 && !hold_done) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (items_sent >= 600 && !pause_done) begin
                pause_done = 1'b1;
                wait_for_results();
            end
            quiet = (items_sent >= 700 && items_sent < 900);
            pick = $urandom_range(99);
            if (pick < 2)
                clock_count = {$urandom, $urandom};
            else if (pick < 5)
                clock_count = clock_count + 64'($urandom_range(60000, 140000));
            pick = $urandom_range(99);
            if (pick < 15) begin
                program_timer();
            end else if (pick < 35) begin
                n = $urandom_range(1, 6);
                repeat (n) issue(OP_TICK, 8'($urandom), 8'($urandom));
            end else if (pick < 50) begin
                n = $urandom_range(1, 20);
                repeat (n) issue(OP_RX, 8'($urandom), 8'($urandom));
            end else if (pick < 65) begin
                n = $urandom_range(1, 20);
                repeat (n) issue(OP_READ, OFF_SER_DATA, 8'($urandom));
            end else if (pick < 75) begin
                read_mapped();
            end else if (pick < 83) begin
                if ($urandom_range(1))
                    issue(OP_WRITE, OFF_SER_CTL, 8'($urandom));
                else
                    issue(OP_WRITE, OFF_SER_DATA, 8'($urandom));
            end else begin
                issue(t_op'($urandom_range(3)), 8'($urandom), 8'($urandom));
            end
        end
        quiet = 1'b0;

        @(negedge i_clk);
        i_valid = 1'b0;
        for (guard = 0; guard < 5000 && sb.pending() != 0; guard++)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        sb.flush_leftover();
        if (sb.fail_count == 0)
            $display("timer_serial_io_page_tb passed");
        else
            $display("timer_serial_io_page_tb failed");
        $finish;
    end

endmodule
